### sv/eps_pkg.sv
package eps_pkg;

	// Field widths of the channels and registers.
	localparam int PERIOD_BITS = 16;
	localparam int NUM_BITS    = 40;
	localparam int SPEED_BITS  = 32;
	localparam int SUM_BITS    = SPEED_BITS + 2;
	localparam int CMD_BITS    = 2;
	localparam int CFG_IDX_BITS = 1;

	// The divider retires two quotient bits per cycle.
	localparam int DIV_STEPS    = NUM_BITS / 2;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

	// The three-speed sum is divided by three as a product with 2^35 / 3 rounded up,
	// which is exact for every sum below 2^35. The sum is fed to the multiplier in two
	// halves on consecutive cycles.
	localparam int RECIP_BITS  = 34;
	localparam int RECIP_SHIFT = 35;
	localparam logic [RECIP_BITS-1:0] RECIP_THIRD = 34'h2AAAAAAAB;
	localparam int AVG_SPLIT   = SUM_BITS / 2;
	localparam int PROD_BITS   = AVG_SPLIT + RECIP_BITS;
	localparam int ACC_BITS    = PROD_BITS + AVG_SPLIT;

	// Command codes carried by an input transfer.
	localparam logic [CMD_BITS-1:0] CMD_CAPTURE  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_OVERFLOW = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_SAMPLE   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_NUMERATOR  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PERIOD = 1'b1;

	// Register reset values.
	localparam logic [NUM_BITS-1:0]    NUMERATOR_RESET  = 40'd5227567360;
	localparam logic [PERIOD_BITS-1:0] MIN_PERIOD_RESET = 16'd18;

	localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic overflow;
		logic clear_ready;
		logic shift_hist;
		logic div_start_raw;
		logic div_step;
		logic avg_load;
		logic avg_low;
		logic avg_high;
		logic commit_avg;
		logic out_load;
		logic out_updated;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic period_ready;
		logic period_ok;
		logic div_last;
	} dp_status_t;

endpackage

### sv/eps_in_if.sv
interface eps_in_if;
	logic                             valid;
	logic                             ready;
	logic [eps_pkg::CMD_BITS-1:0]     command;
	logic [eps_pkg::PERIOD_BITS-1:0]  period_ticks;

	modport source (output valid, output command, output period_ticks, input ready);
	modport sink (input valid, input command, input period_ticks, output ready);
endinterface

### sv/eps_out_if.sv
interface eps_out_if;
	logic                            valid;
	logic                            ready;
	logic [eps_pkg::SPEED_BITS-1:0]  speed;
	logic                            updated;

	modport source (output valid, output speed, output updated, input ready);
	modport sink (input valid, input speed, input updated, output ready);
endinterface

### sv/eps_dp.sv
module eps_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  eps_pkg::ctrl_cmd_t                cmd,
	input  logic [eps_pkg::PERIOD_BITS-1:0]   period_ticks,
	input  logic                              cfg_we,
	input  logic [eps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [eps_pkg::NUM_BITS-1:0]      cfg_data,
	output eps_pkg::dp_status_t               status,
	output logic [eps_pkg::SPEED_BITS-1:0]    speed,
	output logic                              updated
);

	logic [eps_pkg::NUM_BITS-1:0]     numerator_q;
	logic [eps_pkg::PERIOD_BITS-1:0]  min_period_q;
	logic [eps_pkg::PERIOD_BITS-1:0]  latched_q;
	logic                             ready_q;
	logic [eps_pkg::SPEED_BITS-1:0]   last_q;
	logic [eps_pkg::SPEED_BITS-1:0]   older_q;
	logic [eps_pkg::SPEED_BITS-1:0]   speed_q;
	logic                             updated_q;

	// Restoring divider for the numerator over the period: remainder,
	// dividend/quotient shifter, divisor.
	logic [eps_pkg::PERIOD_BITS-1:0]  rem_q;
	logic [eps_pkg::NUM_BITS-1:0]     quo_q;
	logic [eps_pkg::PERIOD_BITS-1:0]  dvs_q;
	logic [eps_pkg::DIV_CNT_BITS-1:0] cnt_q;

	// Averaging: registered sum and the accumulated reciprocal product.
	logic [eps_pkg::SUM_BITS-1:0]     sum_q;
	logic [eps_pkg::ACC_BITS-1:0]     acc_q;

	logic [eps_pkg::PERIOD_BITS:0]    trial1, trial2, dvs_ext;
	logic                             ge1, ge2;
	logic [eps_pkg::PERIOD_BITS-1:0]  rem1, rem2;
	logic [eps_pkg::SPEED_BITS-1:0]   raw_sat;
	logic [eps_pkg::SUM_BITS-1:0]     sum;
	logic [eps_pkg::AVG_SPLIT-1:0]    mul_in;
	logic [eps_pkg::PROD_BITS-1:0]    prod;

	assign dvs_ext = {1'b0, dvs_q};
	assign trial1  = {rem_q, quo_q[eps_pkg::NUM_BITS-1]};
	assign ge1     = trial1 >= dvs_ext;
	assign rem1    = ge1 ? eps_pkg::PERIOD_BITS'(trial1 - dvs_ext)
	                     : trial1[eps_pkg::PERIOD_BITS-1:0];
	assign trial2  = {rem1, quo_q[eps_pkg::NUM_BITS-2]};
	assign ge2     = trial2 >= dvs_ext;
	assign rem2    = ge2 ? eps_pkg::PERIOD_BITS'(trial2 - dvs_ext)
	                     : trial2[eps_pkg::PERIOD_BITS-1:0];

	// A quotient above 32 bits saturates; a zero divisor yields all ones.
	assign raw_sat = (|quo_q[eps_pkg::NUM_BITS-1:eps_pkg::SPEED_BITS]) ? eps_pkg::SPEED_MAX
	               : quo_q[eps_pkg::SPEED_BITS-1:0];
	assign sum = eps_pkg::SUM_BITS'(older_q) + eps_pkg::SUM_BITS'(last_q)
	           + eps_pkg::SUM_BITS'(raw_sat);

	// One constant multiplier takes the low half of the sum, then the high half.
	assign mul_in = cmd.avg_high ? sum_q[eps_pkg::SUM_BITS-1:eps_pkg::AVG_SPLIT]
	                             : sum_q[eps_pkg::AVG_SPLIT-1:0];
	assign prod   = eps_pkg::PROD_BITS'(mul_in) * eps_pkg::PROD_BITS'(eps_pkg::RECIP_THIRD);

	assign status.period_ready = ready_q;
	assign status.period_ok    = latched_q >= min_period_q;
	assign status.div_last     = cnt_q == '0;

	assign speed   = speed_q;
	assign updated = updated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_q  <= eps_pkg::NUMERATOR_RESET;
			min_period_q <= eps_pkg::MIN_PERIOD_RESET;
			latched_q    <= '0;
			ready_q      <= 1'b0;
			last_q       <= '0;
			older_q      <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					eps_pkg::REG_NUMERATOR:  numerator_q <= cfg_data;
					eps_pkg::REG_MIN_PERIOD: begin
						min_period_q <= cfg_data[eps_pkg::PERIOD_BITS-1:0];
					end
					default: ;
				endcase
			end
			if (cmd.capture) begin
				latched_q <= period_ticks;
				ready_q   <= 1'b1;
			end
			if (cmd.overflow) begin
				last_q  <= '0;
				ready_q <= 1'b0;
			end
			if (cmd.clear_ready) begin
				ready_q <= 1'b0;
			end
			if (cmd.shift_hist) begin
				older_q <= last_q;
			end
			if (cmd.commit_avg) begin
				older_q <= last_q;
				last_q  <= acc_q[eps_pkg::RECIP_SHIFT +: eps_pkg::SPEED_BITS];
			end
			if (cmd.div_start_raw) begin
				cnt_q <= eps_pkg::DIV_CNT_BITS'(eps_pkg::DIV_STEPS - 1);
			end else if (cmd.div_step && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start_raw) begin
			rem_q <= '0;
			quo_q <= numerator_q;
			dvs_q <= latched_q;
		end else if (cmd.div_step) begin
			rem_q <= rem2;
			quo_q <= {quo_q[eps_pkg::NUM_BITS-3:0], ge1, ge2};
		end
		if (cmd.avg_load) begin
			sum_q <= sum;
		end
		if (cmd.avg_low) begin
			acc_q <= {{eps_pkg::AVG_SPLIT{1'b0}}, prod};
		end else if (cmd.avg_high) begin
			acc_q <= acc_q + {prod, {eps_pkg::AVG_SPLIT{1'b0}}};
		end
		if (cmd.out_load) begin
			speed_q   <= last_q;
			updated_q <= cmd.out_updated;
		end
	end

endmodule

### sv/eps_ctrl.sv
module eps_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [eps_pkg::CMD_BITS-1:0]  in_command,
	input  logic                          out_ready,
	input  eps_pkg::dp_status_t           status,
	output eps_pkg::ctrl_cmd_t            cmd,
	output logic                          in_ready,
	output logic                          out_valid
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_RAW,
		ST_AVG_LOAD,
		ST_AVG_LOW,
		ST_AVG_HIGH,
		ST_COMMIT,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   upd_q;
	logic   accept;
	logic   use_div;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign use_div   = status.period_ready && status.period_ok;

	always_comb begin
		cmd = '0;
		cmd.out_updated = upd_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_command)
						eps_pkg::CMD_CAPTURE:  cmd.capture = 1'b1;
						eps_pkg::CMD_OVERFLOW: cmd.overflow = 1'b1;
						eps_pkg::CMD_SAMPLE: begin
							cmd.clear_ready = 1'b1;
							if (use_div) begin
								cmd.div_start_raw = 1'b1;
							end else begin
								cmd.shift_hist = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_DIV_RAW:  cmd.div_step = 1'b1;
			ST_AVG_LOAD: cmd.avg_load = 1'b1;
			ST_AVG_LOW:  cmd.avg_low = 1'b1;
			ST_AVG_HIGH: cmd.avg_high = 1'b1;
			ST_COMMIT:   cmd.commit_avg = 1'b1;
			ST_RESULT:   cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			upd_q       <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						upd_q <= (in_command == eps_pkg::CMD_SAMPLE) && status.period_ready;
						if (in_command == eps_pkg::CMD_SAMPLE && use_div) begin
							state_q <= ST_DIV_RAW;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_DIV_RAW: begin
					if (status.div_last) begin
						state_q <= ST_AVG_LOAD;
					end
				end
				ST_AVG_LOAD: state_q <= ST_AVG_LOW;
				ST_AVG_LOW:  state_q <= ST_AVG_HIGH;
				ST_AVG_HIGH: state_q <= ST_COMMIT;
				ST_COMMIT:   state_q <= ST_RESULT;
				ST_RESULT: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted transfer did not leave idle");

	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_RESULT)
		else $error("output valid rose outside the result state");

	a_commit_after_product: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMMIT |-> $past(state_q) == ST_AVG_HIGH)
		else $error("average committed before the reciprocal product finished");

	a_avg_after_raw: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_AVG_LOAD |-> $past(state_q) == ST_DIV_RAW && $past(status.div_last))
		else $error("average load before the period division finished");
`endif

endmodule

### sv/encoder_period_speed_estimator.sv
// Channel   Direction  Payload                             Transfer when
// item      in         command[1:0], period_ticks[15:0]    item.valid && item.ready
// result    out        speed[31:0], updated                result.valid && result.ready
// cfg       in         cfg_index[0], cfg_data[39:0]        cfg_we
//
// An item holds the block from its transfer cycle through the cycle that loads its result.
// A capture, overflow, unused or sample command that does not divide goes from the transfer
// straight to the load. A sample that divides runs the transfer, the numerator divided by
// the period at two quotient bits a cycle, a step that registers the three-speed sum, the
// two halves of its product with the reciprocal of three, the average commit and the load.
// Reset clears the controller, the speed history and the ready mark, and puts the
// registers at their defaults. The block takes a new item while a result still waits
// in the output register; it stalls only when a second result finds that register full.
module encoder_period_speed_estimator (
	input  logic                              clk,
	input  logic                              arst_n,
	eps_in_if.sink                            item,
	eps_out_if.source                         result,
	input  logic                              cfg_we,
	input  logic [eps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [eps_pkg::NUM_BITS-1:0]      cfg_data
);

	// Command and status bundles between the controller and the datapath.
	eps_pkg::ctrl_cmd_t   cmd;
	eps_pkg::dp_status_t  status;

	// The controller sequences each item: it decodes the command at the transfer,
	// walks the divider through the period division, steps the averaging product,
	// and then waits for room in the output register.
	eps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_command (item.command),
		.out_ready  (result.ready),
		.status     (status),
		.cmd        (cmd),
		.in_ready   (item.ready),
		.out_valid  (result.valid)
	);

	// The datapath holds the configuration registers, the latched period, the
	// two-entry speed history, the period divider, the averaging multiplier and
	// the output payload register.
	eps_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.period_ticks (item.period_ticks),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.status       (status),
		.speed        (result.speed),
		.updated      (result.updated)
	);

endmodule

### sim/tb_encoder_period_speed_estimator.sv
module tb_encoder_period_speed_estimator;

	// The package names three commands; the fourth code is reserved and must be ignored.
	localparam logic [eps_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

	// This pause outlasts the work of a dividing sample, so it is enough for the
	// block to settle before registers change or the run ends.
	localparam int IDLE_PAUSE = 60;

	// Items offered in each phase of the random test.
	localparam int PHASE_ITEMS = 125;

	typedef struct packed {
		logic [eps_pkg::SPEED_BITS-1:0] speed;
		logic                           updated;
	} speed_result_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [eps_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [eps_pkg::NUM_BITS-1:0]     cfg_data;

	eps_in_if  in_ch ();
	eps_out_if out_ch ();

	encoder_period_speed_estimator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (in_ch),
		.result    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// The testbench's own copy of the estimator: registers first, then the state that
	// the commands move. All of it follows the block's reset values.
	logic [eps_pkg::NUM_BITS-1:0]    est_numerator;
	logic [eps_pkg::PERIOD_BITS-1:0] est_min_period;
	logic [eps_pkg::PERIOD_BITS-1:0] est_period;
	logic                            est_period_ready;
	logic [eps_pkg::SPEED_BITS-1:0]  est_last_speed;
	logic [eps_pkg::SPEED_BITS-1:0]  est_older_speed;

	// Speeds that the block still owes, oldest first.
	speed_result_t expected_speeds[$];

	int  mismatches;
	int  transfers_in;
	bit  src_gaps_on;
	bit  sink_gaps_on;
	int  sink_hold;

	always #2 clk = ~clk;

	// Applies one command to the predicted state and returns the result that the block
	// must produce for it.
	function automatic speed_result_t estimate_speed(logic [eps_pkg::CMD_BITS-1:0] cmd,
			logic [eps_pkg::PERIOD_BITS-1:0] ticks);
		speed_result_t                   res;
		logic [eps_pkg::NUM_BITS-1:0]    quotient;
		logic [eps_pkg::SPEED_BITS-1:0]  raw;
		logic [eps_pkg::SPEED_BITS+1:0]  sum;
		res.updated = 1'b0;
		case (cmd)
			eps_pkg::CMD_CAPTURE: begin
				est_period       = ticks;
				est_period_ready = 1'b1;
			end
			eps_pkg::CMD_OVERFLOW: begin
				// A stopped wheel: the last speed drops to zero, the older one survives.
				est_last_speed   = '0;
				est_period_ready = 1'b0;
			end
			eps_pkg::CMD_SAMPLE: begin
				if (est_period_ready) begin
					res.updated      = 1'b1;
					est_period_ready = 1'b0;
					if (est_period < est_min_period) begin
						// A glitch period only ages the history.
						est_older_speed = est_last_speed;
					end else begin
						// A zero period divides to the saturated speed.
						if (est_period == '0) begin
							raw = eps_pkg::SPEED_MAX;
						end else begin
							quotient = est_numerator /
								{{(eps_pkg::NUM_BITS-eps_pkg::PERIOD_BITS){1'b0}}, est_period};
							raw = (quotient > {{(eps_pkg::NUM_BITS-eps_pkg::SPEED_BITS){1'b0}},
								eps_pkg::SPEED_MAX}) ?
								eps_pkg::SPEED_MAX : quotient[eps_pkg::SPEED_BITS-1:0];
						end
						sum = {2'b00, est_older_speed} + {2'b00, est_last_speed} + {2'b00, raw};
						est_older_speed = est_last_speed;
						est_last_speed  = eps_pkg::SPEED_BITS'(sum / 3);
					end
				end else begin
					est_older_speed = est_last_speed;
				end
			end
			default: begin
				// The reserved command leaves everything as it is.
			end
		endcase
		res.speed = est_last_speed;
		return res;
	endfunction

	task automatic note_mismatch(string what, speed_result_t want, speed_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected speed %0d updated %0b, got speed %0d updated %0b",
				$realtime, what, want.speed, want.updated, got.speed, got.updated);
	endtask

	// Every result transfer is held against the oldest expectation.
	always @(posedge clk) begin
		speed_result_t want;
		speed_result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.speed   = out_ch.speed;
			got.updated = out_ch.updated;
			if (expected_speeds.size() == 0) begin
				note_mismatch("result with nothing outstanding", '0, got);
			end else begin
				want = expected_speeds.pop_front();
				if (got.speed !== want.speed || got.updated !== want.updated)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	// The receiver. It may stall before each result when gaps are on, and
	// takes one long hold-off whenever a test asks for it.
	initial begin : result_sink
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				stall     = sink_hold;
				sink_hold = 0;
			end else begin
				stall = sink_gaps_on ? $urandom_range(0, 3) : 0;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Offers one item and waits for its transfer. Valid stays high on return so that a
	// following item with no gap is offered with no break in valid.
	task automatic send_item(logic [eps_pkg::CMD_BITS-1:0] cmd,
			logic [eps_pkg::PERIOD_BITS-1:0] ticks);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.command      <= cmd;
		in_ch.period_ticks <= ticks;
		do @(posedge clk); while (!in_ch.ready);
		expected_speeds.push_back(estimate_speed(cmd, ticks));
		transfers_in++;
	endtask

	// Stops offering, waits for every owed result and lets the block run dry.
	task automatic wait_for_idle();
		in_ch.valid <= 1'b0;
		while (expected_speeds.size() != 0) @(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	// Writes one register and mirrors it in the predictor. Only called while idle.
	task automatic program_reg(logic [eps_pkg::CFG_IDX_BITS-1:0] idx,
			logic [eps_pkg::NUM_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == eps_pkg::REG_NUMERATOR)
			est_numerator = value;
		else
			est_min_period = value[eps_pkg::PERIOD_BITS-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic capture_and_sample(logic [eps_pkg::PERIOD_BITS-1:0] ticks);
		send_item(eps_pkg::CMD_CAPTURE, ticks);
		send_item(eps_pkg::CMD_SAMPLE, '0);
	endtask

	// Reset values, every command, glitch periods, a cleared ready mark, a capture that
	// replaces an earlier one and the reserved command between capture and sample.
	task automatic test_commands();
		src_gaps_on  = 1'b1;
		sink_gaps_on = 1'b1;
		send_item(eps_pkg::CMD_SAMPLE, '0);
		send_item(CMD_UNUSED, '1);
		capture_and_sample(eps_pkg::MIN_PERIOD_RESET);
		capture_and_sample(eps_pkg::MIN_PERIOD_RESET - 16'd1);
		capture_and_sample('0);
		capture_and_sample('1);
		send_item(eps_pkg::CMD_CAPTURE, 16'd100);
		send_item(eps_pkg::CMD_OVERFLOW, 16'h5555);
		send_item(eps_pkg::CMD_SAMPLE, 16'hAAAA);
		send_item(eps_pkg::CMD_CAPTURE, 16'd1000);
		capture_and_sample(16'd20);
		send_item(eps_pkg::CMD_CAPTURE, eps_pkg::MIN_PERIOD_RESET);
		send_item(CMD_UNUSED, '0);
		send_item(eps_pkg::CMD_SAMPLE, '0);
		wait_for_idle();
	endtask

	// Register extremes: a full numerator with no glitch floor drives the quotient and the
	// average into saturation, and a zero period is accepted; a zero numerator with the
	// highest floor lets only the longest period through.
	task automatic test_register_extremes();
		program_reg(eps_pkg::REG_NUMERATOR, '1);
		program_reg(eps_pkg::REG_MIN_PERIOD, '0);
		capture_and_sample('0);
		capture_and_sample(16'd1);
		capture_and_sample(16'd2);
		capture_and_sample('1);
		wait_for_idle();
		program_reg(eps_pkg::REG_NUMERATOR, '0);
		program_reg(eps_pkg::REG_MIN_PERIOD,
			{{(eps_pkg::NUM_BITS-eps_pkg::PERIOD_BITS){1'b1}}, 16'hFFFF});
		capture_and_sample(16'hFFFE);
		capture_and_sample('1);
		send_item(eps_pkg::CMD_OVERFLOW, '0);
		wait_for_idle();
		program_reg(eps_pkg::REG_NUMERATOR, eps_pkg::NUMERATOR_RESET);
		program_reg(eps_pkg::REG_MIN_PERIOD, eps_pkg::NUM_BITS'(eps_pkg::MIN_PERIOD_RESET));
	endtask

	// Periods cluster around the glitch floor, with uniform, short and extreme values mixed in.
	function automatic logic [eps_pkg::PERIOD_BITS-1:0] pick_period();
		int roll;
		int p;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			p = int'(est_min_period) + int'($urandom_range(0, 8)) - 4;
			if (p < 0) p = 0;
			if (p > 65535) p = 65535;
			return eps_pkg::PERIOD_BITS'(p);
		end
		if (roll < 70) return eps_pkg::PERIOD_BITS'($urandom_range(0, 65535));
		if (roll < 90) return eps_pkg::PERIOD_BITS'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: return '0;
			1: return 16'd1;
			2: return '1;
			default: return est_min_period;
		endcase
	endfunction

	// Mostly capture-then-sample pairs, which are what move the speed history; the rest
	// are stray overflows, samples and captures and the reserved command.
	task automatic send_random_sequence();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			capture_and_sample(pick_period());
		end else if (roll < 70) begin
			send_item(eps_pkg::CMD_CAPTURE, pick_period());
			capture_and_sample(pick_period());
		end else if (roll < 80) begin
			send_item(eps_pkg::CMD_OVERFLOW, eps_pkg::PERIOD_BITS'($urandom));
		end else if (roll < 90) begin
			send_item(eps_pkg::CMD_SAMPLE, eps_pkg::PERIOD_BITS'($urandom));
		end else if (roll < 96) begin
			send_item(eps_pkg::CMD_CAPTURE, pick_period());
		end else begin
			send_item(CMD_UNUSED, eps_pkg::PERIOD_BITS'($urandom));
		end
	endtask

	// Several register settings in turn. Gaps on either side switch with the phase so
	// that some phases run back to back.
	task automatic test_random_traffic();
		logic [eps_pkg::NUM_BITS-1:0]    num;
		logic [eps_pkg::PERIOD_BITS-1:0] floor_ticks;
		int                              phase_end;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: num = eps_pkg::NUMERATOR_RESET;
				1: num = {8'($urandom_range(0, 255)), 32'($urandom)};
				2: num = eps_pkg::NUM_BITS'($urandom_range(0, 4000000));
				default: num = '1 - eps_pkg::NUM_BITS'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 3))
				0: floor_ticks = '0;
				1: floor_ticks = eps_pkg::MIN_PERIOD_RESET;
				2: floor_ticks = eps_pkg::PERIOD_BITS'($urandom_range(0, 300));
				default: floor_ticks = eps_pkg::PERIOD_BITS'($urandom_range(0, 65535));
			endcase
			program_reg(eps_pkg::REG_NUMERATOR, num);
			// The upper data bits are don't-care for the floor register.
			program_reg(eps_pkg::REG_MIN_PERIOD, {24'($urandom), floor_ticks});
			src_gaps_on  = phase[0];
			sink_gaps_on = phase[1];
			phase_end = transfers_in + PHASE_ITEMS;
			while (transfers_in < phase_end)
				send_random_sequence();
			wait_for_idle();
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering back to
	// back, so the output register fills and the block has to stall its input.
	task automatic test_output_backpressure();
		src_gaps_on  = 1'b0;
		sink_gaps_on = 1'b0;
		sink_hold    = 400;
		repeat (12) capture_and_sample(pick_period());
		wait_for_idle();
		src_gaps_on  = 1'b1;
		sink_gaps_on = 1'b1;
		sink_hold    = 150;
		repeat (8) capture_and_sample(pick_period());
		wait_for_idle();
	endtask

	initial begin : main
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		in_ch.valid        = 1'b0;
		in_ch.command      = '0;
		in_ch.period_ticks = '0;
		mismatches         = 0;
		transfers_in       = 0;
		src_gaps_on        = 1'b0;
		sink_gaps_on       = 1'b0;
		sink_hold          = 0;
		est_numerator      = eps_pkg::NUMERATOR_RESET;
		est_min_period     = eps_pkg::MIN_PERIOD_RESET;
		est_period         = '0;
		est_period_ready   = 1'b0;
		est_last_speed     = '0;
		est_older_speed    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands();
		test_register_extremes();
		test_random_traffic();
		test_output_backpressure();
		wait_for_idle();

		if (mismatches == 0 && expected_speeds.size() == 0) begin
			$display("tb_encoder_period_speed_estimator: PASS");
		end else begin
			$display("tb_encoder_period_speed_estimator: FAIL");
		end
		$finish;
	end

	// A hung handshake ends the run here. The slowest correct run stays well inside it.
	initial begin : watchdog
		#2000000;
		$display("tb_encoder_period_speed_estimator: FAIL");
		$finish;
	end

endmodule

### files.f
sv/eps_pkg.sv
sv/eps_in_if.sv
sv/eps_out_if.sv
sv/eps_dp.sv
sv/eps_ctrl.sv
sv/encoder_period_speed_estimator.sv
sim/tb_encoder_period_speed_estimator.sv
